[design/akf_pkg.sv]
// ----------------------------------------------------------------------------
// akf_pkg
// Types, constants, saturation helpers and the micro-op programs of the
// altitude Kalman filter core.
// ----------------------------------------------------------------------------
package akf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int ACC_W         = 64;
  localparam int NOISE_W       = 31;
  localparam int PC_W          = 5;
  localparam int CFG_ADDR_W    = 2;
  localparam int DEN_W         = 33;

  localparam logic [CFG_ADDR_W-1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BARO_NOISE = 2'd1;
  localparam logic [NOISE_W-1:0]    NOISE_RESET    = 31'd65536;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_SKIP = 2'd2;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] accel;
    logic [15:0]        step_time;
    logic signed [31:0] measured_alt;
  } akf_in_t;

  typedef struct packed {
    logic signed [31:0] altitude;
    logic signed [31:0] velocity;
    logic [1:0]         status;
  } akf_out_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_ADDS, OP_SUBS, OP_DIV, OP_CHK
  } op_t;

  typedef enum logic [4:0] {
    SEL_ALT, SEL_VEL, SEL_P00, SEL_P01, SEL_P10, SEL_P11,
    SEL_DT, SEL_D2, SEL_D3, SEL_D4, SEL_X, SEL_T, SEL_S, SEL_Y,
    SEL_K0, SEL_K1, SEL_ACC, SEL_MEAS, SEL_QN, SEL_BARO,
    SEL_HALF, SEL_QTR, SEL_NONE
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t dst;
    sel_t a;
    sel_t b;
    logic last;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_MULW, ST_DIVW, ST_DONE
  } st_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    else if (v < -ACC_W'(64'sh8000_0000)) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    return (v > ACC_W'(64'sh7FFF_FFFF)) || (v < -ACC_W'(64'sh8000_0000));
  endfunction

  function automatic uop_t mk(input op_t op, input sel_t dst, input sel_t a,
                              input sel_t b, input logic last);
    uop_t u;
    u.op = op; u.dst = dst; u.a = a; u.b = b; u.last = last;
    return u;
  endfunction

  // Predict: motion integration, then covariance terms from the old values.
  function automatic uop_t predict_uop(input logic [PC_W-1:0] pc);
    case (pc)
      5'd0:    return mk(OP_MUL,  SEL_D2,  SEL_DT,   SEL_DT,  1'b0);
      5'd1:    return mk(OP_MUL,  SEL_D3,  SEL_D2,   SEL_DT,  1'b0);
      5'd2:    return mk(OP_MUL,  SEL_D4,  SEL_D2,   SEL_D2,  1'b0);
      5'd3:    return mk(OP_MUL,  SEL_T,   SEL_ACC,  SEL_D2,  1'b0);
      5'd4:    return mk(OP_MUL,  SEL_T,   SEL_HALF, SEL_T,   1'b0);
      5'd5:    return mk(OP_MUL,  SEL_X,   SEL_VEL,  SEL_DT,  1'b0);
      5'd6:    return mk(OP_ADD,  SEL_X,   SEL_X,    SEL_T,   1'b0);
      5'd7:    return mk(OP_ADDS, SEL_ALT, SEL_ALT,  SEL_X,   1'b0);
      5'd8:    return mk(OP_MUL,  SEL_X,   SEL_ACC,  SEL_DT,  1'b0);
      5'd9:    return mk(OP_ADDS, SEL_VEL, SEL_VEL,  SEL_X,   1'b0);
      5'd10:   return mk(OP_ADD,  SEL_X,   SEL_P10,  SEL_P01, 1'b0);
      5'd11:   return mk(OP_MUL,  SEL_X,   SEL_DT,   SEL_X,   1'b0);
      5'd12:   return mk(OP_MUL,  SEL_T,   SEL_D2,   SEL_P11, 1'b0);
      5'd13:   return mk(OP_ADD,  SEL_X,   SEL_X,    SEL_T,   1'b0);
      5'd14:   return mk(OP_MUL,  SEL_T,   SEL_QTR,  SEL_D4,  1'b0);
      5'd15:   return mk(OP_MUL,  SEL_T,   SEL_T,    SEL_QN,  1'b0);
      5'd16:   return mk(OP_ADD,  SEL_X,   SEL_X,    SEL_T,   1'b0);
      5'd17:   return mk(OP_ADDS, SEL_P00, SEL_P00,  SEL_X,   1'b0);
      5'd18:   return mk(OP_MUL,  SEL_X,   SEL_DT,   SEL_P11, 1'b0);
      5'd19:   return mk(OP_MUL,  SEL_T,   SEL_HALF, SEL_D3,  1'b0);
      5'd20:   return mk(OP_MUL,  SEL_T,   SEL_T,    SEL_QN,  1'b0);
      5'd21:   return mk(OP_ADD,  SEL_X,   SEL_X,    SEL_T,   1'b0);
      5'd22:   return mk(OP_ADDS, SEL_P01, SEL_P01,  SEL_X,   1'b0);
      5'd23:   return mk(OP_MUL,  SEL_X,   SEL_DT,   SEL_P11, 1'b0);
      5'd24:   return mk(OP_ADD,  SEL_X,   SEL_X,    SEL_T,   1'b0);
      5'd25:   return mk(OP_ADDS, SEL_P10, SEL_P10,  SEL_X,   1'b0);
      5'd26:   return mk(OP_MUL,  SEL_X,   SEL_D2,   SEL_QN,  1'b0);
      5'd27:   return mk(OP_ADDS, SEL_P11, SEL_P11,  SEL_X,   1'b1);
      default: return mk(OP_ADD,  SEL_NONE, SEL_NONE, SEL_NONE, 1'b1);
    endcase
  endfunction

  // Update: gains first, then state, then covariance in an order that keeps
  // every old term alive until its last use.
  function automatic uop_t update_uop(input logic [PC_W-1:0] pc);
    case (pc)
      5'd0:    return mk(OP_ADD,  SEL_S,   SEL_P00,  SEL_BARO, 1'b0);
      5'd1:    return mk(OP_CHK,  SEL_NONE, SEL_S,   SEL_NONE, 1'b0);
      5'd2:    return mk(OP_SUBS, SEL_Y,   SEL_MEAS, SEL_ALT, 1'b0);
      5'd3:    return mk(OP_DIV,  SEL_K0,  SEL_P00,  SEL_S,   1'b0);
      5'd4:    return mk(OP_DIV,  SEL_K1,  SEL_P10,  SEL_S,   1'b0);
      5'd5:    return mk(OP_MUL,  SEL_X,   SEL_K0,   SEL_Y,   1'b0);
      5'd6:    return mk(OP_ADDS, SEL_ALT, SEL_ALT,  SEL_X,   1'b0);
      5'd7:    return mk(OP_MUL,  SEL_X,   SEL_K1,   SEL_Y,   1'b0);
      5'd8:    return mk(OP_ADDS, SEL_VEL, SEL_VEL,  SEL_X,   1'b0);
      5'd9:    return mk(OP_MUL,  SEL_X,   SEL_K1,   SEL_P00, 1'b0);
      5'd10:   return mk(OP_SUBS, SEL_P10, SEL_P10,  SEL_X,   1'b0);
      5'd11:   return mk(OP_MUL,  SEL_X,   SEL_K1,   SEL_P01, 1'b0);
      5'd12:   return mk(OP_SUBS, SEL_P11, SEL_P11,  SEL_X,   1'b0);
      5'd13:   return mk(OP_MUL,  SEL_X,   SEL_K0,   SEL_P00, 1'b0);
      5'd14:   return mk(OP_SUBS, SEL_P00, SEL_P00,  SEL_X,   1'b0);
      5'd15:   return mk(OP_MUL,  SEL_X,   SEL_K0,   SEL_P01, 1'b0);
      5'd16:   return mk(OP_SUBS, SEL_P01, SEL_P01,  SEL_X,   1'b1);
      default: return mk(OP_ADD,  SEL_NONE, SEL_NONE, SEL_NONE, 1'b1);
    endcase
  endfunction

endpackage

[design/akf_alu.sv]
// ----------------------------------------------------------------------------
// akf_alu
// Shared arithmetic unit: registered 32x32 multiply with rounding, and
// wide add/subtract with optional saturation to 32 bits.
// ----------------------------------------------------------------------------
module akf_alu #(
  parameter int FracBits = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  akf_pkg::op_t                     op,
  input  logic signed [akf_pkg::ACC_W-1:0] a,
  input  logic signed [akf_pkg::ACC_W-1:0] b,
  output logic signed [akf_pkg::ACC_W-1:0] res,
  output logic                             sat
);
  import akf_pkg::*;

  localparam logic signed [ACC_W-1:0] Half = ACC_W'(1) <<< (FracBits - 1);

  logic signed [ACC_W-1:0] prod_r;
  logic                    prod_sat_r;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] dif;
  logic signed [31:0]      sa;
  logic signed [31:0]      sb;

  assign sa  = sat32(a);
  assign sb  = sat32(b);
  assign sum = a + b;
  assign dif = a - b;

  // Product stage: captured every cycle, consumed in the cycle after issue.
  always_ff @(posedge clk) begin
    prod_r     <= ACC_W'(sa) * ACC_W'(sb);
    prod_sat_r <= ovf32(a) | ovf32(b);
  end

  always_comb begin
    res = sum;
    sat = 1'b0;
    case (op)
      OP_MUL: begin
        res = (prod_r + Half) >>> FracBits;
        sat = prod_sat_r;
      end
      OP_ADDS: begin
        res = ACC_W'(sat32(sum));
        sat = ovf32(sum);
      end
      OP_SUBS: begin
        res = ACC_W'(sat32(dif));
        sat = ovf32(dif);
      end
      default: begin
        res = sum;
        sat = 1'b0;
      end
    endcase
  end

endmodule

[design/akf_div.sv]
// ----------------------------------------------------------------------------
// akf_div
// Restoring divider, one quotient bit a cycle: (num * 2^FracBits) / den,
// truncated toward zero and saturated to 32 bits. den is positive.
// ----------------------------------------------------------------------------
module akf_div #(
  parameter int FracBits = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [31:0]            num,
  input  logic [akf_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic signed [31:0]            quot,
  output logic                          sat
);
  import akf_pkg::*;

  localparam int NumW = 32 + FracBits;
  localparam int CntW = $clog2(NumW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CntW-1:0]   cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [NumW-1:0]   numer_r;
  logic              neg_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_dif;
  logic              qbit;
  logic [31:0]       mag_in;
  logic              hi_pos;
  logic              hi_neg;

  assign mag_in  = num[31] ? 32'(-num) : 32'(num);
  assign rem_sh  = {rem_r, numer_r[NumW-1]};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign qbit    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CntW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(NumW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numer_r <= NumW'(mag_in) << FracBits;
      rem_r   <= '0;
      den_r   <= den;
      neg_r   <= num[31];
    end else if (busy_r) begin
      numer_r <= {numer_r[NumW-2:0], qbit};
      rem_r   <= qbit ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  // Clamp the magnitude to the signed 32-bit range.
  assign hi_pos = |numer_r[NumW-1:31];
  assign hi_neg = (|numer_r[NumW-1:32]) || (numer_r[31] && (|numer_r[30:0]));

  always_comb begin
    if (neg_r) begin
      sat  = hi_neg;
      quot = hi_neg ? 32'sh8000_0000 : 32'(-numer_r[31:0]);
    end else begin
      sat  = hi_pos;
      quot = hi_pos ? 32'sh7FFF_FFFF : $signed(numer_r[31:0]);
    end
  end

  assign done = done_r;

endmodule

[design/altitude_kalman_filter_core.sv]
// ----------------------------------------------------------------------------
// altitude_kalman_filter_core
// Two-state altitude/velocity Kalman filter in signed fixed point, run by a
// micro-op sequencer over one shared multiply/add unit and one divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per filter step. cmd predict integrates accel over
//           step_time and grows the covariance; cmd update fuses a
//           barometric altitude. in_ready is high only while the sequencer
//           is idle, so one request is in flight at a time.
//   out_* : one result per request: altitude, velocity and status (ok,
//           saturated, or update skipped on a non-positive variance).
//   cfg_* : write-only noise registers; the user writes them only while the block is idle (not enforced by the block).
// Sequence: predict runs 28 micro-ops, 16 of them multiplies through the
//   registered product stage. Update runs two divisions on the bit-serial
//   divider; a skipped update stops at the variance check, before the
//   divisions. A new request is taken only after the previous result has
//   been loaded into the output register.
// Reset (synchronous, rst_n low): estimates zero, both variances 10.0,
//   noise registers 65536 (1.0 at FRAC_BITS 16), no result pending.
// Stall: a finished result sits in the output register; the next request is
//   accepted meanwhile and its result waits until the output drains.
// ----------------------------------------------------------------------------
module altitude_kalman_filter_core #(
  parameter int FracBits = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  akf_pkg::akf_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output akf_pkg::akf_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [akf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [akf_pkg::NOISE_W-1:0]       cfg_wdata
);
  import akf_pkg::*;

  localparam logic signed [31:0]      CovReset = 32'sd10 <<< FracBits;
  localparam logic signed [ACC_W-1:0] HalfQ    = ACC_W'(1) <<< (FracBits - 1);
  localparam logic signed [ACC_W-1:0] QtrQ     = ACC_W'(1) <<< (FracBits - 2);

  // Sequencer
  st_t             state_r, state_nxt;
  logic [PC_W-1:0] pc_r;
  uop_t            uop;

  // Filter state and noise registers
  logic signed [31:0] alt_r, vel_r, p00_r, p01_r, p10_r, p11_r;
  logic [NOISE_W-1:0] qn_r, baro_r;

  // Scratch registers of the micro-op programs
  logic signed [31:0]      dt_r, d2_r, d3_r, d4_r, y_r, k0_r, k1_r;
  logic signed [ACC_W-1:0] x_r, t_r, s_r;
  logic signed [31:0]      accel_r, meas_r;
  logic                    cmd_r;
  logic                    sat_r, skip_r;

  // Output register
  logic     out_valid_r;
  akf_out_t out_data_r;

  // Datapath
  logic signed [31:0]      dt_in;
  logic signed [ACC_W-1:0] a_val, b_val, alu_res, wr_val;
  logic                    alu_sat;
  logic                    div_done, div_sat;
  logic signed [31:0]      div_q;

  // Control
  logic in_acc;
  logic wr_en, pc_inc, div_start, sat_set, skip_set, out_load;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign uop      = (cmd_r == CMD_UPDATE) ? update_uop(pc_r) : predict_uop(pc_r);

  // Step time into the working fraction width.
  generate
    if (FracBits >= 16) begin : g_dt_up
      assign dt_in = 32'(in_data.step_time) <<< (FracBits - 16);
    end else begin : g_dt_dn
      logic [16:0] dt_rnd;
      assign dt_rnd = {1'b0, in_data.step_time} + 17'(1 << (15 - FracBits));
      assign dt_in  = 32'(dt_rnd >> (16 - FracBits));
    end
  endgenerate

  function automatic logic signed [ACC_W-1:0] opnd(input sel_t s);
    case (s)
      SEL_ALT:  return ACC_W'(alt_r);
      SEL_VEL:  return ACC_W'(vel_r);
      SEL_P00:  return ACC_W'(p00_r);
      SEL_P01:  return ACC_W'(p01_r);
      SEL_P10:  return ACC_W'(p10_r);
      SEL_P11:  return ACC_W'(p11_r);
      SEL_DT:   return ACC_W'(dt_r);
      SEL_D2:   return ACC_W'(d2_r);
      SEL_D3:   return ACC_W'(d3_r);
      SEL_D4:   return ACC_W'(d4_r);
      SEL_X:    return x_r;
      SEL_T:    return t_r;
      SEL_S:    return s_r;
      SEL_Y:    return ACC_W'(y_r);
      SEL_K0:   return ACC_W'(k0_r);
      SEL_K1:   return ACC_W'(k1_r);
      SEL_ACC:  return ACC_W'(accel_r);
      SEL_MEAS: return ACC_W'(meas_r);
      SEL_QN:   return ACC_W'({1'b0, qn_r});
      SEL_BARO: return ACC_W'({1'b0, baro_r});
      SEL_HALF: return HalfQ;
      SEL_QTR:  return QtrQ;
      default:  return '0;
    endcase
  endfunction

  assign a_val = opnd(uop.a);
  assign b_val = opnd(uop.b);

  akf_alu #(.FracBits(FracBits)) u_alu (
    .clk (clk),
    .op  (uop.op),
    .a   (a_val),
    .b   (b_val),
    .res (alu_res),
    .sat (alu_sat)
  );

  akf_div #(.FracBits(FracBits)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (a_val[31:0]),
    .den   (b_val[DEN_W-1:0]),
    .done  (div_done),
    .quot  (div_q),
    .sat   (div_sat)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_RUN;
      ST_RUN: begin
        case (uop.op)
          OP_MUL:  state_nxt = ST_MULW;
          OP_DIV:  state_nxt = ST_DIVW;
          OP_CHK:  if (a_val <= 0) state_nxt = ST_DONE;
          default: if (uop.last) state_nxt = ST_DONE;
        endcase
      end
      ST_MULW: state_nxt = uop.last ? ST_DONE : ST_RUN;
      ST_DIVW: if (div_done) state_nxt = ST_RUN;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    wr_en     = 1'b0;
    wr_val    = alu_res;
    pc_inc    = 1'b0;
    div_start = 1'b0;
    sat_set   = 1'b0;
    skip_set  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_RUN: begin
        case (uop.op)
          OP_MUL: ;
          OP_DIV: div_start = 1'b1;
          OP_CHK: begin
            if (a_val <= 0) skip_set = 1'b1;
            else pc_inc = 1'b1;
          end
          default: begin
            wr_en   = 1'b1;
            sat_set = alu_sat;
            pc_inc  = !uop.last;
          end
        endcase
      end
      ST_MULW: begin
        wr_en   = 1'b1;
        sat_set = alu_sat;
        pc_inc  = !uop.last;
      end
      ST_DIVW: begin
        if (div_done) begin
          wr_en   = 1'b1;
          wr_val  = ACC_W'(div_q);
          sat_set = div_sat;
          pc_inc  = 1'b1;
        end
      end
      ST_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      sat_r       <= 1'b0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Clear per-request flags on accept, advance the program counter.
      if (in_acc) begin
        pc_r   <= '0;
        sat_r  <= 1'b0;
        skip_r <= 1'b0;
      end else begin
        if (pc_inc)   pc_r   <= pc_r + PC_W'(1);
        if (sat_set)  sat_r  <= 1'b1;
        if (skip_set) skip_r <= 1'b1;
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Latch the request fields on accept and the result into the output register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_data.cmd;
      accel_r <= in_data.accel;
      meas_r  <= in_data.measured_alt;
      dt_r    <= dt_in;
    end
    if (out_load) begin
      out_data_r.altitude <= alt_r;
      out_data_r.velocity <= vel_r;
      out_data_r.status   <= skip_r ? STATUS_SKIP : (sat_r ? STATUS_SAT : STATUS_OK);
    end
  end

  // Filter state and noise registers: reset to the initial estimate, then written by config writes and write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_r  <= '0;
      vel_r  <= '0;
      p00_r  <= CovReset;
      p01_r  <= '0;
      p10_r  <= '0;
      p11_r  <= CovReset;
      qn_r   <= NOISE_RESET;
      baro_r <= NOISE_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROC_NOISE: qn_r   <= cfg_wdata;
          REG_BARO_NOISE: baro_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (wr_en) begin
        case (uop.dst)
          SEL_ALT: alt_r <= wr_val[31:0];
          SEL_VEL: vel_r <= wr_val[31:0];
          SEL_P00: p00_r <= wr_val[31:0];
          SEL_P01: p01_r <= wr_val[31:0];
          SEL_P10: p10_r <= wr_val[31:0];
          SEL_P11: p11_r <= wr_val[31:0];
          default: ;
        endcase
      end
    end
  end

  // Scratch write-back.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (uop.dst)
        SEL_D2:  d2_r <= wr_val[31:0];
        SEL_D3:  d3_r <= wr_val[31:0];
        SEL_D4:  d4_r <= wr_val[31:0];
        SEL_X:   x_r  <= wr_val;
        SEL_T:   t_r  <= wr_val;
        SEL_S:   s_r  <= wr_val;
        SEL_Y:   y_r  <= wr_val[31:0];
        SEL_K0:  k0_r <= wr_val[31:0];
        SEL_K1:  k1_r <= wr_val[31:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/akf_checker.sv]
// ----------------------------------------------------------------------------
// akf_checker
// Port-level checks of the altitude Kalman filter core, bound to the top.
// ----------------------------------------------------------------------------
module akf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input akf_pkg::akf_out_t  out_data
);
  import akf_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Drop ready after a request is taken: one request in flight.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_SAT ||
                   out_data.status == STATUS_SKIP))
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left a result pending or the block busy");

endmodule

bind altitude_kalman_filter_core akf_checker u_akf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
